FILE: hdl/aalr_pkg.sv
package aalr_pkg;

    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int SLOPE_FRAC_BITS = 16;
    localparam int COVERAGE_BITS   = 8;

    localparam int COORD_W = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int PIX_W   = COORD_INT_BITS + 1;
    localparam int SLOPE_W = SLOPE_FRAC_BITS + 2;
    localparam int ACC_W   = COORD_W + SLOPE_FRAC_BITS - COORD_FRAC_BITS + 2;
    localparam int D_W     = COORD_FRAC_BITS + 2;
    localparam int GAP_W   = COORD_FRAC_BITS + 1;
    localparam int FRAC_W  = SLOPE_FRAC_BITS + 1;
    localparam int DVD_W   = COORD_W + SLOPE_FRAC_BITS;
    localparam int DVS_W   = COORD_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int CT_W    = FRAC_W + GAP_W + COVERAGE_BITS + 1;
    localparam int C1_W    = FRAC_W + COVERAGE_BITS + 1;

    localparam int HALF_F  = (1 << COORD_FRAC_BITS) >> 1;
    localparam int COV_MAX = (1 << COVERAGE_BITS) - 1;
    localparam logic [FRAC_W-1:0] ONE_F = FRAC_W'(1) << SLOPE_FRAC_BITS;

    localparam logic KIND_NEW = 1'b0;
    localparam logic KIND_ADV = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_DIV, ST_ENDP,
        ST_E0, ST_E1, ST_E2, ST_E3, ST_A0, ST_A1
    } state_t;

    typedef enum logic [2:0] {
        SEL_E0_LO, SEL_E0_HI, SEL_E1_LO, SEL_E1_HI, SEL_ADV_LO, SEL_ADV_HI
    } emit_sel_t;

    typedef struct packed {
        logic      load_raw;
        logic      setup;
        logic      endp;
        logic      emit;
        emit_sel_t sel;
        logic      adv_step;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic active;
        logic out_free;
    } status_t;

    // Endpoint coverage from a Q.16 fraction and a gap given in coordinate units.
    function automatic logic [COVERAGE_BITS-1:0] cov_two(input logic [FRAC_W-1:0] a,
                                                         input logic [GAP_W-1:0] g);
        logic [CT_W-1:0] prod;
        logic [CT_W-1:0] sh;
        prod = CT_W'(a) * CT_W'(g) * CT_W'(COV_MAX)
             + (CT_W'(1) << (SLOPE_FRAC_BITS + COORD_FRAC_BITS - 1));
        sh = prod >> (SLOPE_FRAC_BITS + COORD_FRAC_BITS);
        if (sh > CT_W'(COV_MAX))
            return COVERAGE_BITS'(COV_MAX);
        return sh[COVERAGE_BITS-1:0];
    endfunction

    function automatic logic [COVERAGE_BITS-1:0] cov_one(input logic [FRAC_W-1:0] f);
        logic [C1_W-1:0] prod;
        logic [C1_W-1:0] sh;
        prod = C1_W'(f) * C1_W'(COV_MAX) + (C1_W'(1) << (SLOPE_FRAC_BITS - 1));
        sh = prod >> SLOPE_FRAC_BITS;
        if (sh > C1_W'(COV_MAX))
            return COVERAGE_BITS'(COV_MAX);
        return sh[COVERAGE_BITS-1:0];
    endfunction

endpackage

FILE: hdl/aalr_div.sv
module aalr_div
    import aalr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    logic [DVS_W:0]         rem_reg, rem_next;
    logic [DVD_W-1:0]       quo_reg, quo_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic [DVS_W:0]         shifted;
    logic [DVS_W+1:0]       trial;
    logic                   ge;

    always_comb
    begin
        shifted = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        trial   = {1'b0, shifted} - {2'b0, dvs_reg};
        ge      = !trial[DVS_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[DVS_W:0] : shifted;
            quo_next  = {quo_reg[DVD_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            busy_next = cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/aalr_dp.sv
module aalr_dp
    import aalr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [COORD_W-1:0]       start_x,
    input  logic [COORD_W-1:0]       start_y,
    input  logic [COORD_W-1:0]       end_x,
    input  logic [COORD_W-1:0]       end_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIX_W-1:0]         pixel_x,
    output logic [PIX_W-1:0]         pixel_y,
    output logic [COVERAGE_BITS-1:0] coverage,
    output logic                     last,
    output logic                     line_done
);

    function automatic logic signed [ACC_W-1:0] end_minor(input logic [COORD_W-1:0] x,
                                                          input logic [COORD_W-1:0] y,
                                                          input logic signed [SLOPE_W-1:0] s);
        logic [COORD_W:0]              xh;
        logic [PIX_W-1:0]              xr;
        logic signed [COORD_W+1:0]     dl;
        logic signed [D_W-1:0]         d;
        logic signed [SLOPE_W+D_W-1:0] p;
        logic signed [ACC_W-1:0]       pe;
        logic signed [ACC_W-1:0]       yb;
        xh = {1'b0, x} + (COORD_W+1)'(HALF_F);
        xr = xh[COORD_W:COORD_FRAC_BITS];
        dl = signed'({1'b0, xr, {COORD_FRAC_BITS{1'b0}}}) - signed'({2'b0, x});
        d  = dl[D_W-1:0];
        p  = s * d;
        pe = ACC_W'(p) >>> COORD_FRAC_BITS;
        yb = signed'({2'b0, y, {(SLOPE_FRAC_BITS-COORD_FRAC_BITS){1'b0}}});
        return yb + pe;
    endfunction

    logic [COORD_W-1:0] rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic               steep_reg, neg_reg, dxz_reg;
    logic               active_reg, active_next;
    logic [PIX_W-1:0]   column_reg, column_next;
    logic [PIX_W-1:0]   stop_reg, stop_next;
    logic signed [ACC_W-1:0]   accum_reg, accum_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic signed [ACC_W-1:0]   ye0_reg, ye1_reg;
    logic [PIX_W-1:0]   xp0_reg, xp1_reg;
    logic [GAP_W-1:0]   g0_reg, g1_reg;
    logic               done_reg;

    logic               ov_reg, ov_next;
    logic [PIX_W-1:0]   px_reg, py_reg;
    logic [COVERAGE_BITS-1:0] cov_reg;
    logic               last_reg, ldone_reg;

    // Setup: major axis, endpoint order, divider operands.
    logic [COORD_W-1:0] adx, ady, ax0, ay0, ax1, ay1, ox0, oy0, ox1, oy1, ody;
    logic               steep_w, swap_w, neg_w;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic               div_busy;
    logic [DVD_W-1:0]   quotient;

    always_comb
    begin
        adx = (rx1_reg >= rx0_reg) ? rx1_reg - rx0_reg : rx0_reg - rx1_reg;
        ady = (ry1_reg >= ry0_reg) ? ry1_reg - ry0_reg : ry0_reg - ry1_reg;
        steep_w = ady > adx;
        ax0 = steep_w ? ry0_reg : rx0_reg;
        ay0 = steep_w ? rx0_reg : ry0_reg;
        ax1 = steep_w ? ry1_reg : rx1_reg;
        ay1 = steep_w ? rx1_reg : ry1_reg;
        swap_w = ax0 > ax1;
        ox0 = swap_w ? ax1 : ax0;
        oy0 = swap_w ? ay1 : ay0;
        ox1 = swap_w ? ax0 : ax1;
        oy1 = swap_w ? ay0 : ay1;
        neg_w = oy1 < oy0;
        ody = neg_w ? oy0 - oy1 : oy1 - oy0;
        dividend = {ody, {SLOPE_FRAC_BITS{1'b0}}};
        divisor  = ox1 - ox0;
    end

    aalr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.setup),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Endpoint evaluation once the slope is known.
    logic signed [SLOPE_W-1:0] slope_w;
    logic signed [ACC_W-1:0]   ye0_w, ye1_w;
    logic [COORD_W:0]          xh0, xh1;
    logic [PIX_W-1:0]          xp0_w, xp1_w, col0_w;

    always_comb
    begin
        if (dxz_reg)
            slope_w = signed'(SLOPE_W'(ONE_F));
        else if (neg_reg)
            slope_w = -signed'(quotient[SLOPE_W-1:0]);
        else
            slope_w = signed'(quotient[SLOPE_W-1:0]);
        ye0_w  = end_minor(x0_reg, y0_reg, slope_w);
        ye1_w  = end_minor(x1_reg, y1_reg, slope_w);
        xh0    = {1'b0, x0_reg} + (COORD_W+1)'(HALF_F);
        xh1    = {1'b0, x1_reg} + (COORD_W+1)'(HALF_F);
        xp0_w  = xh0[COORD_W:COORD_FRAC_BITS];
        xp1_w  = xh1[COORD_W:COORD_FRAC_BITS];
        col0_w = xp0_w + PIX_W'(1);
    end

    // Result selection.
    logic [PIX_W-1:0]         major_w, minor_w, col1_w, ip_w;
    logic [COVERAGE_BITS-1:0] cov_w;
    logic                     last_w, done_w, adv_more;
    logic [FRAC_W-1:0]        fr_w, fy0_w, fy1_w;

    always_comb
    begin
        col1_w   = column_reg + PIX_W'(1);
        adv_more = col1_w < stop_reg;
        ip_w     = accum_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS];
        fr_w     = {1'b0, accum_reg[SLOPE_FRAC_BITS-1:0]};
        fy0_w    = {1'b0, ye0_reg[SLOPE_FRAC_BITS-1:0]};
        fy1_w    = {1'b0, ye1_reg[SLOPE_FRAC_BITS-1:0]};
        major_w  = column_reg;
        minor_w  = ip_w;
        cov_w    = cov_one(ONE_F - fr_w);
        last_w   = 1'b0;
        done_w   = done_reg;
        case (cmd.sel)
            SEL_E0_LO:
            begin
                major_w = xp0_reg;
                minor_w = ye0_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS];
                cov_w   = cov_two(ONE_F - fy0_w, g0_reg);
            end
            SEL_E0_HI:
            begin
                major_w = xp0_reg;
                minor_w = ye0_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS] + PIX_W'(1);
                cov_w   = cov_two(fy0_w, g0_reg);
            end
            SEL_E1_LO:
            begin
                major_w = xp1_reg;
                minor_w = ye1_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS];
                cov_w   = cov_two(ONE_F - fy1_w, g1_reg);
            end
            SEL_E1_HI:
            begin
                major_w = xp1_reg;
                minor_w = ye1_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS] + PIX_W'(1);
                cov_w   = cov_two(fy1_w, g1_reg);
                last_w  = 1'b1;
            end
            SEL_ADV_LO:
            begin
                done_w = !adv_more;
            end
            SEL_ADV_HI:
            begin
                minor_w = ip_w + PIX_W'(1);
                cov_w   = cov_one(fr_w);
                last_w  = 1'b1;
                done_w  = !adv_more;
            end
            default:
            begin
                last_w = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        column_next = column_reg;
        stop_next   = stop_reg;
        accum_next  = accum_reg;
        slope_next  = slope_reg;
        if (cmd.endp)
        begin
            slope_next  = slope_w;
            accum_next  = ye0_w + ACC_W'(slope_w);
            column_next = col0_w;
            stop_next   = xp1_w;
            active_next = col0_w < xp1_w;
        end
        else if (cmd.adv_step)
        begin
            accum_next  = accum_reg + ACC_W'(slope_reg);
            column_next = col1_w;
            active_next = adv_more;
        end
        ov_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            column_reg <= '0;
            stop_reg   <= '0;
            accum_reg  <= '0;
            slope_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            column_reg <= column_next;
            stop_reg   <= stop_next;
            accum_reg  <= accum_next;
            slope_reg  <= slope_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_raw)
        begin
            rx0_reg <= start_x;
            ry0_reg <= start_y;
            rx1_reg <= end_x;
            ry1_reg <= end_y;
        end
        if (cmd.setup)
        begin
            x0_reg    <= ox0;
            y0_reg    <= oy0;
            x1_reg    <= ox1;
            y1_reg    <= oy1;
            steep_reg <= steep_w;
            neg_reg   <= neg_w;
            dxz_reg   <= ox1 == ox0;
        end
        if (cmd.endp)
        begin
            ye0_reg  <= ye0_w;
            ye1_reg  <= ye1_w;
            xp0_reg  <= xp0_w;
            xp1_reg  <= xp1_w;
            g0_reg   <= GAP_W'(1 << COORD_FRAC_BITS) - GAP_W'(xh0[COORD_FRAC_BITS-1:0]);
            g1_reg   <= GAP_W'(xh1[COORD_FRAC_BITS-1:0]);
            done_reg <= !(col0_w < xp1_w);
        end
        if (cmd.emit)
        begin
            px_reg    <= steep_reg ? minor_w : major_w;
            py_reg    <= steep_reg ? major_w : minor_w;
            cov_reg   <= cov_w;
            last_reg  <= last_w;
            ldone_reg <= done_w;
        end
    end

    assign status.div_busy = div_busy;
    assign status.active   = active_reg;
    assign status.out_free = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign coverage  = cov_reg;
    assign last      = last_reg;
    assign line_done = ldone_reg;

endmodule

FILE: hdl/aalr_ctrl.sv
module aalr_ctrl
    import aalr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    kind,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_NEW)
                    state_next = ST_SETUP;
                else if (accept && status.active)
                    state_next = ST_A0;
            end
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:   if (!status.div_busy) state_next = ST_ENDP;
            ST_ENDP:  state_next = ST_E0;
            ST_E0:    if (status.out_free) state_next = ST_E1;
            ST_E1:    if (status.out_free) state_next = ST_E2;
            ST_E2:    if (status.out_free) state_next = ST_E3;
            ST_E3:    if (status.out_free) state_next = ST_IDLE;
            ST_A0:    if (status.out_free) state_next = ST_A1;
            ST_A1:    if (status.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = SEL_ADV_LO;
        in_ready     = state_reg == ST_IDLE;
        cmd.load_raw = accept && kind == KIND_NEW;
        case (state_reg)
            ST_SETUP: cmd.setup = 1'b1;
            ST_ENDP:  cmd.endp  = 1'b1;
            ST_E0:
            begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_E0_LO;
            end
            ST_E1:
            begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_E0_HI;
            end
            ST_E2:
            begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_E1_LO;
            end
            ST_E3:
            begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_E1_HI;
            end
            ST_A0:
            begin
                cmd.emit = status.out_free;
                cmd.sel  = SEL_ADV_LO;
            end
            ST_A1:
            begin
                cmd.emit     = status.out_free;
                cmd.sel      = SEL_ADV_HI;
                cmd.adv_step = status.out_free;
            end
            default:
            begin
                cmd.setup = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/antialiased_line_rasterizer.sv
// Channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid, in_ready  | kind, start_x, start_y, end_x, end_y
// output   | out_valid, out_ready| pixel_x, pixel_y, coverage, last, line_done
//
// A new-line item is captured, then its endpoints are ordered and the divider
// started, the bit-serial slope divider computes the slope, the endpoint rows
// are evaluated, and then four results are emitted.
// An advance item on a line in progress emits two results.
// Reset (rst_n, asynchronous) leaves no line in progress.
// A stalled output holds the sequencer in place; one item is in work at a time.
module antialiased_line_rasterizer
    import aalr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [COORD_W-1:0]       start_x,
    input  logic [COORD_W-1:0]       start_y,
    input  logic [COORD_W-1:0]       end_x,
    input  logic [COORD_W-1:0]       end_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [PIX_W-1:0]         pixel_x,
    output logic [PIX_W-1:0]         pixel_y,
    output logic [COVERAGE_BITS-1:0] coverage,
    output logic                     last,
    output logic                     line_done
);

    cmd_t    cmd;
    status_t status;

    aalr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    aalr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .coverage  (coverage),
        .last      (last),
        .line_done (line_done)
    );

    // An advance with no line in progress produces nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_ADV && !status.active) |=> in_ready)
        else $error("idle advance item did not complete at once");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == KIND_NEW) |=> !in_ready)
        else $error("new-line item did not start setup");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.div_busy)
        else $error("divider busy while taking items");

endmodule
